// ----- src/pcnms_pkg.sv -----
// Shared types and constants for the per-class box NMS block.
package pcnms_pkg;

	localparam int unsigned MAX_CAND    = 64;
	localparam int unsigned NUM_CLASSES = 80;
	localparam int unsigned IDX_W       = $clog2(MAX_CAND);
	localparam int unsigned CNT_W       = $clog2(MAX_CAND + 1);
	localparam int unsigned CLS_W       = 7;
	localparam int unsigned CRD_W       = 16;
	localparam int unsigned SC_W        = 16;
	localparam int unsigned CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IOU_THR   = CFG_IDX_W'(1);

	localparam logic [SC_W-1:0] SCORE_THR_RST = SC_W'(22938);
	localparam logic [SC_W-1:0] IOU_THR_RST   = SC_W'(6554);

	// drain counter value at which the next select scan starts after a suppression scan
	localparam logic [1:0] DRAIN_LAST = 2'd3;

	typedef struct packed {
		logic [CRD_W-1:0]        h;
		logic [CRD_W-1:0]        w;
		logic signed [CRD_W-1:0] y;
		logic signed [CRD_W-1:0] x;
	} geo_t;

	typedef struct packed {
		logic [SC_W-1:0]  sc;
		logic [CLS_W-1:0] cls;
		logic [SC_W-1:0]  obj;
	} score_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
		logic             match;
	} sup_tag_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
		logic             hit;
	} sup_res_t;

endpackage

// ----- src/pcnms_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module pcnms_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- src/pcnms_iou.sv -----
// Pipelined IoU suppression test: inter * 2^16 >= thr * union, no division.
module pcnms_iou (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [pcnms_pkg::SC_W-1:0] iou_thr,
	input  pcnms_pkg::geo_t            geo_a,
	input  pcnms_pkg::geo_t            geo_b,
	input  pcnms_pkg::sup_tag_t        tag_in,
	output pcnms_pkg::sup_res_t        res
);

	logic signed [19:0] la_x, ra_x, lb_x, rb_x, la_y, ra_y, lb_y, rb_y;
	logic signed [19:0] lmax_x, rmin_x, lmax_y, rmin_y;

	logic signed [20:0] ow_s2, oh_s2;
	logic [16:0]        aw_s2, ah_s2, bw_s2, bh_s2;
	pcnms_pkg::sup_tag_t tag_s2, tag_s3, tag_s4;

	logic        neg_s3, neg_s4;
	logic [33:0] inter_s3, area_a_s3, area_b_s3, inter_s4;
	logic [34:0] uni_s4;

	logic [50:0] lhs, rhs;

	// edges in quarter units: left = 4c - w, right = 4c + w
	always_comb begin
		la_x = {{2{geo_a.x[15]}}, geo_a.x, 2'b00} - 20'($unsigned(geo_a.w));
		ra_x = {{2{geo_a.x[15]}}, geo_a.x, 2'b00} + 20'($unsigned(geo_a.w));
		lb_x = {{2{geo_b.x[15]}}, geo_b.x, 2'b00} - 20'($unsigned(geo_b.w));
		rb_x = {{2{geo_b.x[15]}}, geo_b.x, 2'b00} + 20'($unsigned(geo_b.w));
		la_y = {{2{geo_a.y[15]}}, geo_a.y, 2'b00} - 20'($unsigned(geo_a.h));
		ra_y = {{2{geo_a.y[15]}}, geo_a.y, 2'b00} + 20'($unsigned(geo_a.h));
		lb_y = {{2{geo_b.y[15]}}, geo_b.y, 2'b00} - 20'($unsigned(geo_b.h));
		rb_y = {{2{geo_b.y[15]}}, geo_b.y, 2'b00} + 20'($unsigned(geo_b.h));
		lmax_x = (la_x > lb_x) ? la_x : lb_x;
		rmin_x = (ra_x < rb_x) ? ra_x : rb_x;
		lmax_y = (la_y > lb_y) ? la_y : lb_y;
		rmin_y = (ra_y < rb_y) ? ra_y : rb_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s2 <= tag_in;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		ow_s2 <= 21'(rmin_x) - 21'(lmax_x);
		oh_s2 <= 21'(rmin_y) - 21'(lmax_y);
		aw_s2 <= {geo_a.w, 1'b0};
		ah_s2 <= {geo_a.h, 1'b0};
		bw_s2 <= {geo_b.w, 1'b0};
		bh_s2 <= {geo_b.h, 1'b0};

		neg_s3    <= ow_s2[20] | oh_s2[20];
		inter_s3  <= ow_s2[16:0] * oh_s2[16:0];
		area_a_s3 <= aw_s2 * ah_s2;
		area_b_s3 <= bw_s2 * bh_s2;

		neg_s4   <= neg_s3;
		inter_s4 <= inter_s3;
		uni_s4   <= {1'b0, area_a_s3} + {1'b0, area_b_s3} - {1'b0, inter_s3};
	end

	always_comb begin
		lhs = {1'b0, inter_s4, 16'b0};
		rhs = iou_thr * uni_s4;
		res.vld = tag_s4.vld;
		res.idx = tag_s4.idx;
		res.hit = tag_s4.match & (neg_s4 ? (iou_thr == '0) : (lhs >= rhs));
	end

endmodule

// ----- src/per_class_box_nms.sv -----
// Top level of the per-class greedy box NMS block.
//
// Channels: candidates enter on cand_valid/cand_stall, one beat per box; detections
// leave on det_valid/det_stall, one beat per kept box. Config registers (score and
// IoU thresholds) are written on cfg_valid/cfg_ready, always ready.
// Loading: one candidate per cycle while idle. Boxes below the score threshold or of
// an unknown class are dropped; beyond 64 stored boxes they are dropped and the
// frame's overflow flag is set. Candidates sit in two 64-entry RAMs (geometry, scores).
// The beat with last_candidate set starts NMS and cand_stall stays high until the
// final detection is in the output register. NMS repeats: a select scan over all N
// stored boxes (one RAM read a cycle) picks the alive box of lowest class and
// highest score, then a suppression scan of N reads feeds the IoU pipeline, whose
// results drain before the next select scan. Detections are held one beat back so the
// final one can carry last_result; an empty frame gives one beat with found low. A
// stalled detection holds in the output register and NMS waits. Reset clears counts,
// alive flags and returns to idle; thresholds return to 22938 and 6554.
module per_class_box_nms (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cand_valid,
	output logic                                   cand_stall,
	input  logic signed [pcnms_pkg::CRD_W-1:0]     center_x,
	input  logic signed [pcnms_pkg::CRD_W-1:0]     center_y,
	input  logic [pcnms_pkg::CRD_W-1:0]            box_width,
	input  logic [pcnms_pkg::CRD_W-1:0]            box_height,
	input  logic [pcnms_pkg::SC_W-1:0]             objectness,
	input  logic [pcnms_pkg::CLS_W-1:0]            class_index,
	input  logic [pcnms_pkg::SC_W-1:0]             class_score,
	input  logic                                   last_candidate,
	output logic                                   det_valid,
	input  logic                                   det_stall,
	output logic signed [pcnms_pkg::CRD_W-1:0]     out_center_x,
	output logic signed [pcnms_pkg::CRD_W-1:0]     out_center_y,
	output logic [pcnms_pkg::CRD_W-1:0]            out_width,
	output logic [pcnms_pkg::CRD_W-1:0]            out_height,
	output logic [pcnms_pkg::SC_W-1:0]             out_objectness,
	output logic [pcnms_pkg::CLS_W-1:0]            out_class,
	output logic                                   found,
	output logic                                   overflowed,
	output logic                                   last_result,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pcnms_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pcnms_pkg::SC_W-1:0]             cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEL,
		ST_DECIDE,
		ST_SUP,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

	state_t state_q;

	logic [pcnms_pkg::SC_W-1:0]  score_thr_q, iou_thr_q;
	logic [pcnms_pkg::CNT_W-1:0] cnt_q, idx_q;
	logic                        ovf_q;
	logic [pcnms_pkg::MAX_CAND-1:0] alive_q;
	logic [1:0]                  drain_q;

	// scan stage: address issued to the RAMs last cycle
	logic                        sel_v_s1, sup_v_s1;
	logic [pcnms_pkg::IDX_W-1:0] idx_s1;

	// running best of the select scan
	logic                        best_found_q;
	logic [pcnms_pkg::IDX_W-1:0] best_idx_q;
	pcnms_pkg::geo_t             best_geo_q;
	pcnms_pkg::score_t           best_sc_q;

	// kept box waiting to learn whether it is the frame's last
	logic                        pend_v_q;
	pcnms_pkg::geo_t             pend_geo_q;
	pcnms_pkg::score_t           pend_sc_q;

	logic                        det_valid_q;
	pcnms_pkg::geo_t             det_geo_q;
	pcnms_pkg::score_t           det_sc_q;
	logic                        found_q, ovf_out_q, last_q;

	logic                        cand_acc, keep, full, wr_en, out_free, better;
	logic                        push_pend, push_final;
	pcnms_pkg::geo_t             wr_geo, rd_geo;
	pcnms_pkg::score_t           wr_sc, rd_sc;
	pcnms_pkg::sup_tag_t         sup_tag;
	pcnms_pkg::sup_res_t         sup_res;

	assign cand_stall = (state_q != ST_IDLE);
	assign cand_acc   = cand_valid & ~cand_stall;
	assign cfg_ready  = 1'b1;

	assign keep  = (class_score >= score_thr_q) &&
		({1'b0, class_index} < (pcnms_pkg::CLS_W + 1)'(pcnms_pkg::NUM_CLASSES));
	assign full  = (cnt_q == pcnms_pkg::CNT_W'(pcnms_pkg::MAX_CAND));
	assign wr_en = cand_acc & keep & ~full;

	assign wr_geo = '{h: box_height, w: box_width, y: center_y, x: center_x};
	assign wr_sc  = '{sc: class_score, cls: class_index, obj: objectness};

	pcnms_ram #(
		.WIDTH($bits(pcnms_pkg::geo_t)),
		.DEPTH(pcnms_pkg::MAX_CAND)
	) u_geo_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[pcnms_pkg::IDX_W-1:0]),
		.wr_data (wr_geo),
		.rd_addr (idx_q[pcnms_pkg::IDX_W-1:0]),
		.rd_data (rd_geo)
	);

	pcnms_ram #(
		.WIDTH($bits(pcnms_pkg::score_t)),
		.DEPTH(pcnms_pkg::MAX_CAND)
	) u_score_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[pcnms_pkg::IDX_W-1:0]),
		.wr_data (wr_sc),
		.rd_addr (idx_q[pcnms_pkg::IDX_W-1:0]),
		.rd_data (rd_sc)
	);

	// suppression candidates must share the kept box's class
	assign sup_tag = '{vld: sup_v_s1, idx: idx_s1, match: (rd_sc.cls == best_sc_q.cls)};

	pcnms_iou u_iou (
		.clk     (clk),
		.arst_n  (arst_n),
		.iou_thr (iou_thr_q),
		.geo_a   (best_geo_q),
		.geo_b   (rd_geo),
		.tag_in  (sup_tag),
		.res     (sup_res)
	);

	// lowest class first, then highest score; ties keep the earlier entry
	assign better = alive_q[idx_s1] && (!best_found_q || (rd_sc.cls < best_sc_q.cls) ||
		((rd_sc.cls == best_sc_q.cls) && (rd_sc.sc > best_sc_q.sc)));

	assign out_free   = ~det_valid_q | ~det_stall;
	assign push_pend  = (state_q == ST_DECIDE) & best_found_q & pend_v_q & out_free;
	assign push_final = (state_q == ST_FLUSH) & out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			score_thr_q  <= pcnms_pkg::SCORE_THR_RST;
			iou_thr_q    <= pcnms_pkg::IOU_THR_RST;
			cnt_q        <= '0;
			idx_q        <= '0;
			ovf_q        <= 1'b0;
			alive_q      <= '0;
			drain_q      <= '0;
			sel_v_s1     <= 1'b0;
			sup_v_s1     <= 1'b0;
			best_found_q <= 1'b0;
			pend_v_q     <= 1'b0;
			det_valid_q  <= 1'b0;
		end else begin
			sel_v_s1 <= 1'b0;
			sup_v_s1 <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					pcnms_pkg::REG_SCORE_THR: score_thr_q <= cfg_data;
					pcnms_pkg::REG_IOU_THR:   iou_thr_q   <= cfg_data;
					default: ;
				endcase
			end

			if (det_valid_q && !det_stall) begin
				det_valid_q <= 1'b0;
			end

			if (wr_en) begin
				alive_q[cnt_q[pcnms_pkg::IDX_W-1:0]] <= 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end
			if (cand_acc && keep && full) begin
				ovf_q <= 1'b1;
			end

			if (sel_v_s1 && better) begin
				best_found_q <= 1'b1;
				best_idx_q   <= idx_s1;
				best_geo_q   <= rd_geo;
				best_sc_q    <= rd_sc;
			end

			if (sup_res.vld && sup_res.hit) begin
				alive_q[sup_res.idx] <= 1'b0;
			end

			if (push_pend) begin
				det_valid_q <= 1'b1;
				det_geo_q   <= pend_geo_q;
				det_sc_q    <= pend_sc_q;
				found_q     <= 1'b1;
				ovf_out_q   <= ovf_q;
				last_q      <= 1'b0;
			end else if (push_final) begin
				det_valid_q <= 1'b1;
				det_geo_q   <= pend_v_q ? pend_geo_q : '0;
				det_sc_q    <= pend_v_q ? pend_sc_q : '0;
				found_q     <= pend_v_q;
				ovf_out_q   <= ovf_q;
				last_q      <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cand_acc && last_candidate) begin
						state_q      <= ST_SEL;
						idx_q        <= '0;
						best_found_q <= 1'b0;
					end
				end
				ST_SEL: begin
					if (idx_q == cnt_q) begin
						state_q <= ST_DECIDE;
					end else begin
						sel_v_s1 <= 1'b1;
						idx_s1   <= idx_q[pcnms_pkg::IDX_W-1:0];
						idx_q    <= idx_q + 1'b1;
					end
				end
				ST_DECIDE: begin
					if (!best_found_q) begin
						state_q <= ST_FLUSH;
					end else if (!pend_v_q || out_free) begin
						pend_v_q   <= 1'b1;
						pend_geo_q <= best_geo_q;
						pend_sc_q  <= best_sc_q;
						alive_q[best_idx_q] <= 1'b0;
						idx_q      <= '0;
						state_q    <= ST_SUP;
					end
				end
				ST_SUP: begin
					if (idx_q == cnt_q) begin
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end else begin
						sup_v_s1 <= 1'b1;
						idx_s1   <= idx_q[pcnms_pkg::IDX_W-1:0];
						idx_q    <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (drain_q == pcnms_pkg::DRAIN_LAST) begin
						state_q      <= ST_SEL;
						idx_q        <= '0;
						best_found_q <= 1'b0;
					end else begin
						drain_q <= drain_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						cnt_q    <= '0;
						ovf_q    <= 1'b0;
						alive_q  <= '0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign det_valid      = det_valid_q;
	assign out_center_x   = det_geo_q.x;
	assign out_center_y   = det_geo_q.y;
	assign out_width      = det_geo_q.w;
	assign out_height     = det_geo_q.h;
	assign out_objectness = det_sc_q.obj;
	assign out_class      = det_sc_q.cls;
	assign found          = found_q;
	assign overflowed     = ovf_out_q;
	assign last_result    = last_q;

endmodule
